// ----- hdl/bcp_pkg.sv -----
// Package: shared widths, constants, codes and types of the cascade PID block.
package bcp_pkg;

  // Default target limits
  localparam int SPEED_TARGET_MAX_DEF = 12;
  localparam int TURN_TARGET_MAX_DEF  = 150;
  localparam int TURN_STEP            = 30;
  localparam int INTEG_LIMIT          = 20000;

  // Field widths
  localparam int ENC_W      = 16;
  localparam int ANG_W      = 16;
  localparam int GAIN_W     = 32;
  localparam int MED_W      = 16;
  localparam int LIM_W      = 15;
  localparam int MOT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Datapath widths
  localparam int ERR_W   = 18;
  localparam int NUM_W   = 22;
  localparam int FILT_W  = 18;
  localparam int INTEG_W = 16;
  localparam int ISUM_W  = 19;
  localparam int VSUM_W  = 27;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 66;
  localparam int VX_W    = 29;
  localparam int VEL_W   = 26;
  localparam int DSUM_W  = 36;
  localparam int DIFF_W  = 32;
  localparam int BAL_W   = 42;
  localparam int TURN_W  = 34;
  localparam int OSUM_W  = 43;

  // Reciprocal constants: x/10 and x/25 as multiply and shift
  localparam int DIV10_MUL  = 1677722;
  localparam int DIV10_SH   = 24;
  localparam int DIV25_MUL  = 343597384;
  localparam int DIV25_SH   = 33;
  // Speed loop scaling 200*65536 = 25 * 2^19
  localparam int VEL_PRE_SH = 19;
  localparam int BAL_SH     = 24;
  localparam int TURN_SH    = 16;
  localparam int KD_SH      = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_KP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_KD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_KP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_KP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_KD_HOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MED_ANGLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_LIMIT  = 3'd6;

  // Configuration reset values
  localparam logic signed [GAIN_W-1:0] RST_VERTICAL_KP  = -32'sd7864320;
  localparam logic signed [GAIN_W-1:0] RST_VERTICAL_KD  = -32'sd49152;
  localparam logic signed [GAIN_W-1:0] RST_VELOCITY_KP  = -32'sd72090;
  localparam logic signed [GAIN_W-1:0] RST_TURN_KP      = 32'sd655360;
  localparam logic signed [GAIN_W-1:0] RST_TURN_KD_HOLD = 32'sd39322;
  localparam logic signed [MED_W-1:0]  RST_MED_ANGLE    = 16'sd768;
  localparam logic [LIM_W-1:0]         RST_MOTOR_LIMIT  = 15'd7200;

  // Datapath step codes
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_LOAD   = 5'd0;
  localparam logic [OP_W-1:0] OP_NUM    = 5'd1;
  localparam logic [OP_W-1:0] OP_MDIV10 = 5'd2;
  localparam logic [OP_W-1:0] OP_FILT   = 5'd3;
  localparam logic [OP_W-1:0] OP_INTEG  = 5'd4;
  localparam logic [OP_W-1:0] OP_VSUM   = 5'd5;
  localparam logic [OP_W-1:0] OP_MVEL   = 5'd6;
  localparam logic [OP_W-1:0] OP_VABS   = 5'd7;
  localparam logic [OP_W-1:0] OP_MDIV25 = 5'd8;
  localparam logic [OP_W-1:0] OP_VEL    = 5'd9;
  localparam logic [OP_W-1:0] OP_DIFF   = 5'd10;
  localparam logic [OP_W-1:0] OP_MBAL1  = 5'd11;
  localparam logic [OP_W-1:0] OP_MBAL2  = 5'd12;
  localparam logic [OP_W-1:0] OP_MACC   = 5'd13;
  localparam logic [OP_W-1:0] OP_BALR   = 5'd14;
  localparam logic [OP_W-1:0] OP_TSUM   = 5'd15;
  localparam logic [OP_W-1:0] OP_TURN   = 5'd16;
  localparam logic [OP_W-1:0] OP_OUT    = 5'd17;

  typedef struct packed {
    logic signed [ENC_W-1:0] encoder_left;
    logic signed [ENC_W-1:0] encoder_right;
    logic signed [ANG_W-1:0] roll_angle;
    logic signed [ENC_W-1:0] gyro_x;
    logic signed [ENC_W-1:0] gyro_z;
    logic                    fore_cmd;
    logic                    back_cmd;
    logic                    left_cmd;
    logic                    right_cmd;
    logic                    obstacle_near;
    logic                    clear_integral;
  } bcp_in_t;

  typedef struct packed {
    logic signed [MOT_W-1:0] motor_left;
    logic signed [MOT_W-1:0] motor_right;
  } bcp_out_t;

  typedef struct packed {
    logic            step_en;
    logic [OP_W-1:0] op;
  } bcp_cmd_t;

endpackage

// ----- hdl/bcp_if.sv -----
// Interfaces: input and result channels with valid/ready handshake.
interface bcp_in_if import bcp_pkg::*; ();
  logic    valid;
  logic    ready;
  bcp_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bcp_out_if import bcp_pkg::*; ();
  logic     valid;
  logic     ready;
  bcp_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/balance_robot_cascade_pid.sv -----
// Top level: cascade PID balance controller, one transaction per control tick.
//
//  channel   direction  handshake      payload
//  in_if     sink       valid/ready    encoders, roll angle, gyro x/z, command bits
//  out_if    source     valid/ready    motor_left, motor_right
//  cfg_*     sink       cfg_we only    cfg_index selects register, cfg_data value
//
// An input transaction is accepted only while the sequencer is idle; its result
// is registered in the final step, and the next one is accepted only after it.
// The step sequence length is set by the single shared 33x33 multiplier, used
// in seven steps, plus the filter, integral, clamp and truncation steps around it.
// A result still waiting at the output does not block the next acceptance; only
// the final step holds until the output register is free.
// Synchronous active-low reset clears the loop state and loads register defaults.
module balance_robot_cascade_pid import bcp_pkg::*; #(
  parameter int SPEED_TARGET_MAX = SPEED_TARGET_MAX_DEF,
  parameter int TURN_TARGET_MAX  = TURN_TARGET_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bcp_in_if.sink                in_if,
  bcp_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bcp_cmd_t cmd;
  logic     in_ready;
  logic     out_valid;
  bcp_out_t out_data;

  // Step sequencer
  bcp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  // Arithmetic and state
  bcp_dpath #(
    .SPEED_TARGET_MAX (SPEED_TARGET_MAX),
    .TURN_TARGET_MAX  (TURN_TARGET_MAX)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_if.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
  assign out_if.data  = out_data;

endmodule

// ----- hdl/bcp_dpath.sv -----
// Datapath: loop state, configuration registers, shared multiplier and result register.
module bcp_dpath import bcp_pkg::*; #(
  parameter int SPEED_TARGET_MAX = SPEED_TARGET_MAX_DEF,
  parameter int TURN_TARGET_MAX  = TURN_TARGET_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bcp_cmd_t              cmd,
  input  bcp_in_t               in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output bcp_out_t              out_data
);

  localparam int ST_W  = $clog2(SPEED_TARGET_MAX + 1) + 1;
  localparam int STX_W = ST_W + 2;
  localparam int TT_W  = $clog2(TURN_TARGET_MAX + 1) + 1;
  localparam int TTX_W = TT_W + 2;

  localparam logic signed [STX_W-1:0] ST_HI  = STX_W'(SPEED_TARGET_MAX);
  localparam logic signed [STX_W-1:0] ST_LO  = -ST_HI;
  localparam logic signed [STX_W-1:0] ST_ONE = STX_W'(1);
  localparam logic signed [TTX_W-1:0] TT_HI  = TTX_W'(TURN_TARGET_MAX);
  localparam logic signed [TTX_W-1:0] TT_LO  = -TT_HI;
  localparam logic signed [TTX_W-1:0] TT_STP = TTX_W'(TURN_STEP);
  localparam logic signed [ISUM_W-1:0] I_HI  = ISUM_W'(INTEG_LIMIT);
  localparam logic signed [ISUM_W-1:0] I_LO  = -I_HI;

  // Configuration registers
  logic signed [GAIN_W-1:0] vkp_r, vkd_r, velkp_r, tkp_r, tkd_r;
  logic signed [MED_W-1:0]  med_r;
  logic [LIM_W-1:0]         lim_r;

  // Loop state
  logic signed [ST_W-1:0]    st_r;
  logic signed [TT_W-1:0]    tt_r;
  logic signed [FILT_W-1:0]  filt_r;
  logic signed [INTEG_W-1:0] integ_r;

  // Working registers
  bcp_in_t                  in_r;
  logic [NUM_W-1:0]         num_abs_r;
  logic                     num_neg_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VSUM_W-1:0] vsum_r;
  logic [VX_W-1:0]          vx_r;
  logic                     vneg_r;
  logic signed [VEL_W-1:0]  vel_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [BAL_W-1:0]  bal_r;
  logic signed [TURN_W-1:0] turn_r;
  bcp_out_t                 out_r;

  // Combinational values
  logic signed [STX_W-1:0]   st_sum;
  logic signed [ST_W-1:0]    st_nxt;
  logic signed [TTX_W-1:0]   tt_sum;
  logic signed [TT_W-1:0]    tt_nxt;
  logic signed [ERR_W-1:0]   err;
  logic signed [NUM_W-1:0]   num, fx7;
  logic signed [FILT_W-1:0]  q10, filt_nxt;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [INTEG_W-1:0] integ_nxt;
  logic signed [VSUM_W-1:0]  fxv, vsum_nxt;
  logic signed [PROD_W-1:0]  pabs;
  logic [VX_W-1:0]           vx_nxt;
  logic signed [VEL_W-1:0]   q25, vel_nxt;
  logic signed [DSUM_W-1:0]  dsum;
  logic signed [DIFF_W-1:0]  diff_nxt;
  logic signed [GAIN_W-1:0]  kd_sel;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  acc_b24, acc_b16;
  logic signed [OSUM_W-1:0]  sum_l, sum_r, lim_s;

  function automatic logic signed [MOT_W-1:0] sat_motor(
    input logic signed [OSUM_W-1:0] v,
    input logic signed [OSUM_W-1:0] lim
  );
    logic signed [OSUM_W-1:0] r;
    begin
      if (v > lim) r = lim;
      else if (v < -lim) r = -lim;
      else r = v;
      return MOT_W'(r);
    end
  endfunction

  // Step the speed and turn targets from the remote commands
  always_comb begin
    st_sum = (in_data.fore_cmd | in_data.back_cmd) ? STX_W'(st_r) : '0;
    if (in_data.fore_cmd) st_sum = in_data.obstacle_near ? st_sum + ST_ONE : st_sum - ST_ONE;
    if (in_data.back_cmd) st_sum = st_sum + ST_ONE;
    if (st_sum > ST_HI) st_sum = ST_HI;
    else if (st_sum < ST_LO) st_sum = ST_LO;
    st_nxt = ST_W'(st_sum);

    tt_sum = (in_data.left_cmd | in_data.right_cmd) ? TTX_W'(tt_r) : '0;
    if (in_data.left_cmd) tt_sum = tt_sum + TT_STP;
    if (in_data.right_cmd) tt_sum = tt_sum - TT_STP;
    if (tt_sum > TT_HI) tt_sum = TT_HI;
    else if (tt_sum < TT_LO) tt_sum = TT_LO;
    tt_nxt = TT_W'(tt_sum);
  end

  // Filter numerator 3*err + 7*filt
  always_comb begin
    err = ERR_W'(in_r.encoder_left) + ERR_W'(in_r.encoder_right) - ERR_W'(st_r);
    fx7 = NUM_W'(filt_r);
    num = (NUM_W'(err) <<< 1) + NUM_W'(err) + (fx7 <<< 3) - fx7;
  end

  // Filter result, speed integral and speed loop sum
  always_comb begin
    q10      = signed'(prod_r[DIV10_SH +: FILT_W]);
    filt_nxt = num_neg_r ? -q10 : q10;
    isum     = ISUM_W'(integ_r) + ISUM_W'(filt_r);
    if (isum > I_HI) isum = I_HI;
    else if (isum < I_LO) isum = I_LO;
    integ_nxt = in_r.clear_integral ? '0 : INTEG_W'(isum);
    fxv       = VSUM_W'(filt_r);
    vsum_nxt  = (fxv <<< 7) + (fxv <<< 6) + (fxv <<< 3) + VSUM_W'(integ_r);
  end

  // Speed loop output and angle error
  always_comb begin
    pabs = prod_r[PROD_W-1] ? -prod_r : prod_r;
    if (|pabs[PROD_W-1:VEL_PRE_SH+VX_W]) vx_nxt = '1;
    else vx_nxt = pabs[VEL_PRE_SH +: VX_W];
    q25     = signed'({1'b0, prod_r[DIV25_SH +: VEL_W-1]});
    vel_nxt = vneg_r ? -q25 : q25;
    dsum    = DSUM_W'(in_r.roll_angle) - (DSUM_W'(vel_r) <<< 8) - DSUM_W'(med_r);
    if (dsum[DSUM_W-1:DIFF_W-1] == '0 || dsum[DSUM_W-1:DIFF_W-1] == '1)
      diff_nxt = DIFF_W'(dsum);
    else if (dsum[DSUM_W-1])
      diff_nxt = {1'b1, {(DIFF_W-1){1'b0}}};
    else
      diff_nxt = {1'b0, {(DIFF_W-1){1'b1}}};
  end

  // Operand select for the shared multiplier
  always_comb begin
    kd_sel = (in_r.left_cmd | in_r.right_cmd) ? '0 : tkd_r;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_MDIV10: begin
        mul_a = MUL_W'(num_abs_r);
        mul_b = MUL_W'(DIV10_MUL);
      end
      OP_MVEL: begin
        mul_a = MUL_W'(velkp_r);
        mul_b = MUL_W'(vsum_r);
      end
      OP_MDIV25: begin
        mul_a = MUL_W'(vx_r);
        mul_b = MUL_W'(DIV25_MUL);
      end
      OP_MBAL1: begin
        mul_a = MUL_W'(vkp_r);
        mul_b = MUL_W'(diff_r);
      end
      OP_MBAL2: begin
        mul_a = MUL_W'(vkd_r);
        mul_b = MUL_W'(in_r.gyro_x);
      end
      OP_MACC: begin
        mul_a = MUL_W'(tkp_r);
        mul_b = MUL_W'(tt_r);
      end
      OP_BALR: begin
        mul_a = MUL_W'(kd_sel);
        mul_b = MUL_W'(in_r.gyro_z);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Truncate toward zero and combine the drives
  always_comb begin
    acc_b24 = acc_r + PROD_W'({BAL_SH{acc_r[PROD_W-1]}});
    acc_b16 = acc_r + PROD_W'({TURN_SH{acc_r[PROD_W-1]}});
    lim_s   = OSUM_W'(lim_r);
    sum_l   = OSUM_W'(bal_r) - OSUM_W'(turn_r);
    sum_r   = OSUM_W'(bal_r) + OSUM_W'(turn_r);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vkp_r   <= RST_VERTICAL_KP;
      vkd_r   <= RST_VERTICAL_KD;
      velkp_r <= RST_VELOCITY_KP;
      tkp_r   <= RST_TURN_KP;
      tkd_r   <= RST_TURN_KD_HOLD;
      med_r   <= RST_MED_ANGLE;
      lim_r   <= RST_MOTOR_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTICAL_KP:  vkp_r   <= cfg_data;
        CFG_VERTICAL_KD:  vkd_r   <= cfg_data;
        CFG_VELOCITY_KP:  velkp_r <= cfg_data;
        CFG_TURN_KP:      tkp_r   <= cfg_data;
        CFG_TURN_KD_HOLD: tkd_r   <= cfg_data;
        CFG_MED_ANGLE:    med_r   <= cfg_data[MED_W-1:0];
        CFG_MOTOR_LIMIT:  lim_r   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Loop state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      tt_r    <= '0;
      filt_r  <= '0;
      integ_r <= '0;
    end else if (cmd.step_en) begin
      case (cmd.op)
        OP_LOAD: begin
          st_r <= st_nxt;
          tt_r <= tt_nxt;
        end
        OP_FILT:  filt_r  <= filt_nxt;
        OP_INTEG: integ_r <= integ_nxt;
        default: ;
      endcase
    end
  end

  // Working registers, advanced one step per command
  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      prod_r <= prod_nxt;
      case (cmd.op)
        OP_LOAD: in_r <= in_data;
        OP_NUM: begin
          num_neg_r <= num[NUM_W-1];
          num_abs_r <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        end
        OP_VSUM: vsum_r <= vsum_nxt;
        OP_VABS: begin
          vx_r   <= vx_nxt;
          vneg_r <= prod_r[PROD_W-1];
        end
        OP_VEL:   vel_r  <= vel_nxt;
        OP_DIFF:  diff_r <= diff_nxt;
        OP_MBAL2: acc_r  <= prod_r;
        OP_MACC:  acc_r  <= acc_r + (prod_r <<< KD_SH);
        OP_BALR: begin
          bal_r <= BAL_W'(acc_b24 >>> BAL_SH);
          acc_r <= prod_r;
        end
        OP_TSUM: acc_r  <= acc_r + prod_r;
        OP_TURN: turn_r <= TURN_W'(acc_b16 >>> TURN_SH);
        OP_OUT: begin
          out_r.motor_left  <= sat_motor(sum_l, lim_s);
          out_r.motor_right <= sat_motor(sum_r, lim_s);
        end
        default: ;
      endcase
    end
  end

  assign out_data = out_r;

endmodule

// ----- hdl/bcp_ctrl.sv -----
// Controller: step sequencer, input acceptance and result valid register.
module bcp_ctrl import bcp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bcp_cmd_t cmd
);

  localparam int SW = 5;
  localparam logic [SW-1:0] S_IDLE   = 5'd0;
  localparam logic [SW-1:0] S_NUM    = 5'd1;
  localparam logic [SW-1:0] S_MDIV10 = 5'd2;
  localparam logic [SW-1:0] S_FILT   = 5'd3;
  localparam logic [SW-1:0] S_INTEG  = 5'd4;
  localparam logic [SW-1:0] S_VSUM   = 5'd5;
  localparam logic [SW-1:0] S_MVEL   = 5'd6;
  localparam logic [SW-1:0] S_VABS   = 5'd7;
  localparam logic [SW-1:0] S_MDIV25 = 5'd8;
  localparam logic [SW-1:0] S_VEL    = 5'd9;
  localparam logic [SW-1:0] S_DIFF   = 5'd10;
  localparam logic [SW-1:0] S_MBAL1  = 5'd11;
  localparam logic [SW-1:0] S_MBAL2  = 5'd12;
  localparam logic [SW-1:0] S_MACC   = 5'd13;
  localparam logic [SW-1:0] S_BALR   = 5'd14;
  localparam logic [SW-1:0] S_TSUM   = 5'd15;
  localparam logic [SW-1:0] S_TURN   = 5'd16;
  localparam logic [SW-1:0] S_OUT    = 5'd17;

  logic [SW-1:0] state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_stall;

  assign out_stall = out_valid_r & ~out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequence the datapath steps
  always_comb begin
    state_nxt   = state_r;
    cmd.step_en = (state_r != S_IDLE) && (state_r != S_OUT);
    cmd.op      = OP_LOAD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step_en = 1'b1;
          state_nxt   = S_NUM;
        end
      end
      S_NUM:    begin cmd.op = OP_NUM;    state_nxt = S_MDIV10; end
      S_MDIV10: begin cmd.op = OP_MDIV10; state_nxt = S_FILT;   end
      S_FILT:   begin cmd.op = OP_FILT;   state_nxt = S_INTEG;  end
      S_INTEG:  begin cmd.op = OP_INTEG;  state_nxt = S_VSUM;   end
      S_VSUM:   begin cmd.op = OP_VSUM;   state_nxt = S_MVEL;   end
      S_MVEL:   begin cmd.op = OP_MVEL;   state_nxt = S_VABS;   end
      S_VABS:   begin cmd.op = OP_VABS;   state_nxt = S_MDIV25; end
      S_MDIV25: begin cmd.op = OP_MDIV25; state_nxt = S_VEL;    end
      S_VEL:    begin cmd.op = OP_VEL;    state_nxt = S_DIFF;   end
      S_DIFF:   begin cmd.op = OP_DIFF;   state_nxt = S_MBAL1;  end
      S_MBAL1:  begin cmd.op = OP_MBAL1;  state_nxt = S_MBAL2;  end
      S_MBAL2:  begin cmd.op = OP_MBAL2;  state_nxt = S_MACC;   end
      S_MACC:   begin cmd.op = OP_MACC;   state_nxt = S_BALR;   end
      S_BALR:   begin cmd.op = OP_BALR;   state_nxt = S_TSUM;   end
      S_TSUM:   begin cmd.op = OP_TSUM;   state_nxt = S_TURN;   end
      S_TURN:   begin cmd.op = OP_TURN;   state_nxt = S_OUT;    end
      S_OUT: begin
        cmd.op = OP_OUT;
        // hold here while the previous result is still waiting
        if (!out_stall) begin
          cmd.step_en = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        cmd.step_en = 1'b0;
        state_nxt   = S_IDLE;
      end
    endcase
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    if (state_r == S_OUT && !out_stall) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_NUM))
    else $error("accepted transaction did not start the step sequence");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_stall) |=> (out_valid_r && state_r == S_IDLE))
    else $error("final step did not present a result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_stall) |=> (state_r == S_OUT && out_valid_r))
    else $error("sequencer left final step while result was pending");

  a_steps_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_OUT) |=> (state_r != $past(state_r)))
    else $error("sequencer stalled in a middle step");
`endif

endmodule
